/* hdl/extendible_hash_insert_core_macros.svh */
// Assertion helpers used by the core's control module.
`ifndef EXTENDIBLE_HASH_INSERT_CORE_MACROS_SVH
`define EXTENDIBLE_HASH_INSERT_CORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define EHI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("extendible hash core: check failed");

// Consequent must hold in the same cycle as the antecedent.
`define EHI_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("extendible hash core: check failed");

`endif

/* hdl/ehi_pkg.sv */
package ehi_pkg;

  localparam int KeyW    = 32;
  localparam int BktW    = 8;
  localparam int SlotW   = 3;
  localparam int CntW    = 4;
  localparam int DepthW  = 4;
  localparam int UsedW   = 9;
  localparam int CfgW    = 4;
  localparam int MaxPrefix = 8;
  localparam int MaxCap    = 8;

  localparam logic [1:0] CfgPrefix   = 2'd0;
  localparam logic [1:0] CfgCapacity = 2'd1;

  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic [CntW-1:0]   count;
    logic              cv;
    logic [BktW-1:0]   link;
  } meta_t;

  typedef enum logic [1:0] {
    RES_INS  = 2'd0,
    RES_DUP  = 2'd1,
    RES_FULL = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    SRC_CUR  = 2'd0,
    SRC_HOME = 2'd1,
    SRC_NEW  = 2'd2
  } src_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_DIR_RD, OP_META_RD, OP_KEY_RD, OP_KEY_NEXT,
    OP_CHAIN_RD, OP_PLACE, OP_HOLD_B, OP_LINK, OP_ALLOC, OP_DBL_RD, OP_DBL_W1,
    OP_DBL_W2, OP_SPL_RD, OP_SPL_WR, OP_SPL_MB, OP_SPL_MN, OP_SCAN0, OP_SCAN
  } op_e;

  typedef struct packed {
    op_e  op;
    logic emit;
    res_e res;
    src_e src;
  } cmd_t;

  typedef struct packed {
    logic lt_cap;
    logic at_full;
    logic chained;
    logic pool_full;
    logic need_dbl;
    logic key_hit;
    logic key_end;
    logic spl_end;
    logic dbl_end;
    logic scan_end;
    logic clr_end;
  } stat_t;

endpackage

/* hdl/ehi_datapath.sv */
module ehi_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ehi_pkg::cmd_t               cmd_i,
  output ehi_pkg::stat_t              stat_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ehi_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [ehi_pkg::KeyW-1:0]    key_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [ehi_pkg::BktW-1:0]    bucket_index_o,
  output logic [ehi_pkg::DepthW-1:0]  global_depth_o,
  output logic [ehi_pkg::DepthW-1:0]  local_depth_o
);

  logic [ehi_pkg::CfgW-1:0]   prefix_q, cap_q;
  logic [ehi_pkg::KeyW-1:0]   key_q;
  logic [3:0]                 p_q, c_q, p_d, c_d;
  logic [ehi_pkg::DepthW-1:0] depth_now_q;
  logic [ehi_pkg::UsedW-1:0]  used_q;
  logic [ehi_pkg::BktW-1:0]   b_q, cur_q, nb_q, sp_q, clr_q;
  ehi_pkg::meta_t             bmeta_q;
  logic [3:0]                 j_q, cnt0_q, cnt1_q;
  logic [6:0]                 di_q;
  logic [8:0]                 si_q;

  logic [7:0]                 dir_mem [256];
  logic [7:0]                 dir_rd_q;
  ehi_pkg::meta_t             meta_mem [256];
  ehi_pkg::meta_t             meta_rd_q;
  logic [31:0]                key_mem [2048];
  logic [31:0]                key_rd_q;

  logic       dir_re, dir_we, meta_re, meta_we, key_re, key_we;
  logic [7:0] dir_raddr, dir_waddr, dir_wdata, meta_raddr, meta_waddr;
  ehi_pkg::meta_t meta_wdata;
  logic [10:0] key_raddr, key_waddr;
  logic [31:0] key_wdata;

  logic [7:0] pmask, home;
  logic [3:0] keybit, dirbit;
  logic       done_q;
  logic [1:0] status_q;
  logic [7:0] bucket_q;
  logic [3:0] gdepth_q, ldepth_q;

  // effective prefix and capacity for the next request
  always_comb begin
    p_d = prefix_q;
    if (p_d == 4'd0) p_d = 4'd1;
    if (p_d > 4'(ehi_pkg::MaxPrefix)) p_d = 4'(ehi_pkg::MaxPrefix);
    if (p_d < depth_now_q) p_d = depth_now_q;
    c_d = cap_q;
    if (c_d == 4'd0) c_d = 4'd1;
    if (c_d > 4'(ehi_pkg::MaxCap)) c_d = 4'(ehi_pkg::MaxCap);
  end

  assign pmask  = 8'hFF >> (4'd8 - p_q);
  assign home   = (key_q[7:0] & pmask) >> (p_q - depth_now_q);
  assign keybit = p_q - 4'd1 - bmeta_q.depth;
  assign dirbit = depth_now_q - 4'd1 - bmeta_q.depth;

  always_comb begin
    stat_o.lt_cap    = meta_rd_q.count < c_q;
    stat_o.at_full   = meta_rd_q.depth >= p_q;
    stat_o.chained   = meta_rd_q.cv;
    stat_o.pool_full = used_q[8];
    stat_o.need_dbl  = meta_rd_q.depth >= depth_now_q;
    stat_o.key_hit   = key_rd_q == key_q;
    stat_o.key_end   = j_q >= meta_rd_q.count;
    stat_o.spl_end   = j_q >= bmeta_q.count;
    stat_o.dbl_end   = di_q == 7'd0;
    stat_o.scan_end  = si_q == (9'd1 << depth_now_q);
    stat_o.clr_end   = clr_q == 8'hFF;
  end

  always_comb begin
    dir_re = 1'b0;  dir_raddr = '0;  dir_we = 1'b0;  dir_waddr = '0;  dir_wdata = '0;
    meta_re = 1'b0; meta_raddr = '0; meta_we = 1'b0; meta_waddr = '0; meta_wdata = '0;
    key_re = 1'b0;  key_raddr = '0;  key_we = 1'b0;  key_waddr = '0;  key_wdata = key_q;
    case (cmd_i.op)
      ehi_pkg::OP_CLEAR: begin
        dir_we = 1'b1;  dir_waddr = clr_q;
        meta_we = 1'b1; meta_waddr = clr_q;
      end
      ehi_pkg::OP_DIR_RD: begin
        dir_re = 1'b1; dir_raddr = home;
      end
      ehi_pkg::OP_META_RD: begin
        meta_re = 1'b1; meta_raddr = dir_rd_q;
      end
      ehi_pkg::OP_KEY_RD: begin
        key_re = 1'b1; key_raddr = {cur_q, j_q[2:0]};
      end
      ehi_pkg::OP_CHAIN_RD: begin
        meta_re = 1'b1; meta_raddr = meta_rd_q.link;
      end
      ehi_pkg::OP_PLACE: begin
        key_we = 1'b1; key_waddr = {cur_q, meta_rd_q.count[2:0]};
        meta_we = 1'b1; meta_waddr = cur_q;
        meta_wdata = meta_rd_q;
        meta_wdata.count = meta_rd_q.count + 4'd1;
      end
      ehi_pkg::OP_LINK: begin
        meta_we = 1'b1; meta_waddr = cur_q;
        meta_wdata = meta_rd_q;
        meta_wdata.cv = 1'b1;
        meta_wdata.link = used_q[7:0];
      end
      ehi_pkg::OP_ALLOC: begin
        meta_we = 1'b1; meta_waddr = used_q[7:0];
        meta_wdata = '{depth: bmeta_q.depth, count: 4'd1, cv: 1'b0, link: 8'd0};
        key_we = 1'b1; key_waddr = {used_q[7:0], 3'd0};
      end
      ehi_pkg::OP_DBL_RD: begin
        dir_re = 1'b1; dir_raddr = {1'b0, di_q};
      end
      ehi_pkg::OP_DBL_W1: begin
        dir_we = 1'b1; dir_waddr = {di_q, 1'b1}; dir_wdata = dir_rd_q;
      end
      ehi_pkg::OP_DBL_W2: begin
        dir_we = 1'b1; dir_waddr = {di_q, 1'b0}; dir_wdata = dir_rd_q;
        dir_re = 1'b1; dir_raddr = {1'b0, di_q - 7'd1};
      end
      ehi_pkg::OP_SPL_RD: begin
        key_re = 1'b1; key_raddr = {b_q, j_q[2:0]};
      end
      ehi_pkg::OP_SPL_WR: begin
        key_we = 1'b1; key_wdata = key_rd_q;
        if (key_rd_q[keybit[2:0]]) key_waddr = {used_q[7:0], cnt1_q[2:0]};
        else key_waddr = {b_q, cnt0_q[2:0]};
      end
      ehi_pkg::OP_SPL_MB: begin
        meta_we = 1'b1; meta_waddr = b_q;
        meta_wdata = '{depth: bmeta_q.depth + 4'd1, count: cnt0_q, cv: bmeta_q.cv,
                       link: bmeta_q.link};
      end
      ehi_pkg::OP_SPL_MN: begin
        meta_we = 1'b1; meta_waddr = used_q[7:0];
        meta_wdata = '{depth: bmeta_q.depth + 4'd1, count: cnt1_q, cv: 1'b0, link: 8'd0};
      end
      ehi_pkg::OP_SCAN0: begin
        dir_re = 1'b1; dir_raddr = 8'd0;
      end
      ehi_pkg::OP_SCAN: begin
        // move entries on the upper half of the split bucket to the new bucket
        if (dir_rd_q == b_q && sp_q[dirbit[2:0]]) begin
          dir_we = 1'b1; dir_waddr = sp_q; dir_wdata = nb_q;
        end
        if (!stat_o.scan_end) begin
          dir_re = 1'b1; dir_raddr = si_q[7:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    if (dir_re) dir_rd_q <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (meta_re) meta_rd_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    if (key_re) key_rd_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= 4'd3;
      cap_q       <= 4'd3;
      depth_now_q <= '0;
      used_q      <= 9'd1;
      clr_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cfg_we_i && cfg_index_i == ehi_pkg::CfgPrefix) prefix_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == ehi_pkg::CfgCapacity) cap_q <= cfg_data_i;
      case (cmd_i.op)
        ehi_pkg::OP_CLEAR: clr_q <= clr_q + 8'd1;
        ehi_pkg::OP_ALLOC, ehi_pkg::OP_SPL_MN: used_q <= used_q + 9'd1;
        ehi_pkg::OP_DBL_W2: if (di_q == 7'd0) depth_now_q <= depth_now_q + 4'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ehi_pkg::OP_LOAD: begin
        key_q <= key_i;
        p_q   <= p_d;
        c_q   <= c_d;
      end
      ehi_pkg::OP_META_RD: begin
        b_q <= dir_rd_q; cur_q <= dir_rd_q; j_q <= '0;
      end
      ehi_pkg::OP_KEY_NEXT: j_q <= j_q + 4'd1;
      ehi_pkg::OP_CHAIN_RD: begin
        cur_q <= meta_rd_q.link; j_q <= '0;
      end
      ehi_pkg::OP_HOLD_B: begin
        bmeta_q <= meta_rd_q;
        j_q     <= '0;
        cnt0_q  <= '0;
        cnt1_q  <= '0;
        di_q    <= 7'((8'd1 << depth_now_q) - 8'd1);
      end
      ehi_pkg::OP_DBL_W2: if (di_q != 7'd0) di_q <= di_q - 7'd1;
      ehi_pkg::OP_SPL_WR: begin
        j_q <= j_q + 4'd1;
        if (key_rd_q[keybit[2:0]]) cnt1_q <= cnt1_q + 4'd1;
        else cnt0_q <= cnt0_q + 4'd1;
      end
      ehi_pkg::OP_SPL_MN: nb_q <= used_q[7:0];
      ehi_pkg::OP_SCAN0: begin
        sp_q <= 8'd0; si_q <= 9'd1;
      end
      ehi_pkg::OP_SCAN: if (!stat_o.scan_end) begin
        sp_q <= si_q[7:0]; si_q <= si_q + 9'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.res;
      gdepth_q <= depth_now_q;
      case (cmd_i.src)
        ehi_pkg::SRC_CUR: begin
          bucket_q <= cur_q; ldepth_q <= meta_rd_q.depth;
        end
        ehi_pkg::SRC_HOME: begin
          bucket_q <= b_q; ldepth_q <= bmeta_q.depth;
        end
        default: begin
          bucket_q <= used_q[7:0]; ldepth_q <= bmeta_q.depth;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign bucket_index_o = bucket_q;
  assign global_depth_o = gdepth_q;
  assign local_depth_o  = ldepth_q;

endmodule

/* hdl/ehi_ctrl.sv */
`include "extendible_hash_insert_core_macros.svh"

module ehi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ehi_pkg::stat_t stat_i,
  output ehi_pkg::cmd_t  cmd_o
);

  typedef enum logic [19:0] {
    ST_CLR     = 20'h00001,
    ST_IDLE    = 20'h00002,
    ST_DIR_F   = 20'h00004,
    ST_META_F  = 20'h00008,
    ST_KEY_F   = 20'h00010,
    ST_CMP_F   = 20'h00020,
    ST_DIR_I   = 20'h00040,
    ST_META_I  = 20'h00080,
    ST_CHK_I   = 20'h00100,
    ST_CHK_C   = 20'h00200,
    ST_ALLOC_C = 20'h00400,
    ST_DBL_RD  = 20'h00800,
    ST_DBL_W1  = 20'h01000,
    ST_DBL_W2  = 20'h02000,
    ST_SPL_RD  = 20'h04000,
    ST_SPL_WR  = 20'h08000,
    ST_SPL_MB  = 20'h10000,
    ST_SPL_MN  = 20'h20000,
    ST_SCAN0   = 20'h40000,
    ST_SCAN    = 20'h80000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: ehi_pkg::OP_NONE, emit: 1'b0, res: ehi_pkg::RES_INS,
                src: ehi_pkg::SRC_CUR};
    case (state_q)
      ST_CLR: begin
        cmd_o.op = ehi_pkg::OP_CLEAR;
        if (stat_i.clr_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = ehi_pkg::OP_LOAD;
          state_d  = ST_DIR_F;
        end
      end
      ST_DIR_F: begin
        cmd_o.op = ehi_pkg::OP_DIR_RD;
        state_d  = ST_META_F;
      end
      ST_META_F: begin
        cmd_o.op = ehi_pkg::OP_META_RD;
        state_d  = ST_KEY_F;
      end
      ST_KEY_F: begin
        // walk the home bucket and its chain for the key
        if (!stat_i.key_end) begin
          cmd_o.op = ehi_pkg::OP_KEY_RD;
          state_d  = ST_CMP_F;
        end else if (stat_i.chained) begin
          cmd_o.op = ehi_pkg::OP_CHAIN_RD;
        end else begin
          state_d = ST_DIR_I;
        end
      end
      ST_CMP_F: begin
        if (stat_i.key_hit) begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = ehi_pkg::RES_DUP;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.op = ehi_pkg::OP_KEY_NEXT;
          state_d  = ST_KEY_F;
        end
      end
      ST_DIR_I: begin
        cmd_o.op = ehi_pkg::OP_DIR_RD;
        state_d  = ST_META_I;
      end
      ST_META_I: begin
        cmd_o.op = ehi_pkg::OP_META_RD;
        state_d  = ST_CHK_I;
      end
      ST_CHK_I: begin
        if (stat_i.lt_cap) begin
          cmd_o.op   = ehi_pkg::OP_PLACE;
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else if (stat_i.at_full || stat_i.chained) begin
          cmd_o.op = ehi_pkg::OP_HOLD_B;
          state_d  = ST_CHK_C;
        end else if (stat_i.pool_full) begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = ehi_pkg::RES_FULL;
          state_d    = ST_IDLE;
        end else if (stat_i.need_dbl) begin
          cmd_o.op = ehi_pkg::OP_HOLD_B;
          state_d  = ST_DBL_RD;
        end else begin
          cmd_o.op = ehi_pkg::OP_HOLD_B;
          state_d  = ST_SPL_RD;
        end
      end
      ST_CHK_C: begin
        if (stat_i.lt_cap) begin
          cmd_o.op   = ehi_pkg::OP_PLACE;
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else if (stat_i.chained) begin
          cmd_o.op = ehi_pkg::OP_CHAIN_RD;
        end else if (stat_i.pool_full) begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = ehi_pkg::RES_FULL;
          cmd_o.src  = ehi_pkg::SRC_HOME;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.op = ehi_pkg::OP_LINK;
          state_d  = ST_ALLOC_C;
        end
      end
      ST_ALLOC_C: begin
        cmd_o.op   = ehi_pkg::OP_ALLOC;
        cmd_o.emit = 1'b1;
        cmd_o.src  = ehi_pkg::SRC_NEW;
        state_d    = ST_IDLE;
      end
      ST_DBL_RD: begin
        cmd_o.op = ehi_pkg::OP_DBL_RD;
        state_d  = ST_DBL_W1;
      end
      ST_DBL_W1: begin
        cmd_o.op = ehi_pkg::OP_DBL_W1;
        state_d  = ST_DBL_W2;
      end
      ST_DBL_W2: begin
        cmd_o.op = ehi_pkg::OP_DBL_W2;
        state_d  = stat_i.dbl_end ? ST_SPL_RD : ST_DBL_W1;
      end
      ST_SPL_RD: begin
        if (stat_i.spl_end) begin
          state_d = ST_SPL_MB;
        end else begin
          cmd_o.op = ehi_pkg::OP_SPL_RD;
          state_d  = ST_SPL_WR;
        end
      end
      ST_SPL_WR: begin
        cmd_o.op = ehi_pkg::OP_SPL_WR;
        state_d  = ST_SPL_RD;
      end
      ST_SPL_MB: begin
        cmd_o.op = ehi_pkg::OP_SPL_MB;
        state_d  = ST_SPL_MN;
      end
      ST_SPL_MN: begin
        cmd_o.op = ehi_pkg::OP_SPL_MN;
        state_d  = ST_SCAN0;
      end
      ST_SCAN0: begin
        cmd_o.op = ehi_pkg::OP_SCAN0;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.op = ehi_pkg::OP_SCAN;
        // place the key again after the split
        if (stat_i.scan_end) state_d = ST_DIR_I;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  `EHI_ASSERT_NEXT(a_emit_returns_idle, clk_i, rst_ni, cmd_o.emit, state_q == ST_IDLE)
  `EHI_ASSERT_NEXT(a_start_taken, clk_i, rst_ni, (state_q == ST_IDLE) && start, busy)
  `EHI_ASSERT_NOW(a_link_needs_room, clk_i, rst_ni, cmd_o.op == ehi_pkg::OP_LINK, !stat_i.pool_full)

endmodule

/* hdl/extendible_hash_insert_core.sv */
// Extendible hash insert core. Pulse start with busy low to insert key_i; exactly one
// result follows, shown for one cycle with done_o high, and it cannot be held off.
// After reset the core clears all 256 entries of its directory and bucket tables with
// busy high. An insert first compares key_i with each key in the home bucket and its
// chain. A split moves the keys of the full bucket to two buckets and makes a pass over
// the directory; a directory doubling may come first. Configuration is taken at any time.
module extendible_hash_insert_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ehi_pkg::KeyW-1:0]    key_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ehi_pkg::CfgW-1:0]    cfg_data_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [ehi_pkg::BktW-1:0]    bucket_index_o,
  output logic [ehi_pkg::DepthW-1:0]  global_depth_o,
  output logic [ehi_pkg::DepthW-1:0]  local_depth_o
);

  ehi_pkg::cmd_t  cmd;
  ehi_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  ehi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ehi_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .key_i          (key_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .bucket_index_o (bucket_index_o),
    .global_depth_o (global_depth_o),
    .local_depth_o  (local_depth_o)
  );

endmodule
